>>> rtl/ellpack_element_table_assert.svh
// ============================================================================
// ELLPACK element table assertion macros
// Shared property templates; the using module provides clk and rst_n.
// ============================================================================
`ifndef ELLPACK_ELEMENT_TABLE_ASSERT_SVH
`define ELLPACK_ELEMENT_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EET_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/eet_pkg.sv
// ============================================================================
// eet_pkg
// Shared constants, types and codes of the ELLPACK element table.
// ============================================================================
`timescale 1ns / 1ps

package eet_pkg;

    // Table geometry.
    localparam int MAX_ROWS      = 1024;
    localparam int SLOTS_PER_ROW = 32;
    localparam int MAX_COLUMNS   = 1024;
    localparam int VALUE_BITS    = 32;

    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int SLOT_BITS = $clog2(SLOTS_PER_ROW);
    localparam int COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int DENS_BITS = $clog2(SLOTS_PER_ROW + 1);

    // Field widths of the stream words.
    localparam int ROW_IDX_BITS  = 10;
    localparam int COL_IDX_BITS  = 10;
    localparam int WVAL_BITS     = 32;
    localparam int RVAL_BITS     = 32;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 1;

    localparam int IN_FIELD_BITS  = ROW_IDX_BITS + COL_IDX_BITS + WVAL_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = RVAL_BITS + 1 + SLOT_BITS + DENS_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;
    localparam logic [CFG_BITS-1:0]     ROW_COUNT_RESET    = 11'd1024;
    localparam logic [CFG_BITS-1:0]     COLUMN_COUNT_RESET = 11'd1024;

    // Access modes.
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    // One column tag: a valid bit and the column id.
    typedef struct packed {
        logic                valid;
        logic [COL_BITS-1:0] col;
    } tag_t;

    typedef tag_t [SLOTS_PER_ROW-1:0]                   tag_row_t;
    typedef logic [SLOTS_PER_ROW-1:0][VALUE_BITS-1:0]  value_row_t;

    // Single-slot write request shared by both memories.
    typedef struct packed {
        logic                 we;
        logic [ROW_BITS-1:0]  row;
        logic [SLOT_BITS-1:0] slot;
    } slot_wr_t;

    // Outcome of the slot scan of one row.
    typedef struct packed {
        logic                 found;  // a matching or empty slot exists
        logic                 hit;    // that slot holds the column
        logic [SLOT_BITS-1:0] slot;
    } match_t;

endpackage

>>> rtl/eet_tag_mem.sv
// ============================================================================
// eet_tag_mem
// Row-wide column tag memory with one-slot writes and a row clear port.
// ============================================================================
`timescale 1ns / 1ps

module eet_tag_mem
    import eet_pkg::*;
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ROW_BITS-1:0] rd_row,
    output tag_row_t            rd_data,
    input  slot_wr_t            wr,
    input  tag_t                wr_entry,
    input  logic                clr_en,
    input  logic [ROW_BITS-1:0] clr_row
);

    tag_row_t mem [MAX_ROWS];
    tag_row_t rd_data_reg;

    // The clear sweep runs alone; a slot write never overlaps it.
    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            mem[clr_row] <= '0;
        end
        else if (wr.we)
        begin
            mem[wr.row][wr.slot] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/eet_value_mem.sv
// ============================================================================
// eet_value_mem
// Row-wide value memory with one-slot writes.
// ============================================================================
`timescale 1ns / 1ps

module eet_value_mem
    import eet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ROW_BITS-1:0]   rd_row,
    output value_row_t            rd_data,
    input  slot_wr_t              wr,
    input  logic [VALUE_BITS-1:0] wr_value
);

    value_row_t mem [MAX_ROWS];
    value_row_t rd_data_reg;

    // Values are only returned from slots whose tag is valid, so the
    // array needs no clearing after reset.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.row][wr.slot] <= wr_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/eet_slot_match.sv
// ============================================================================
// eet_slot_match
// Parallel compare of all slots of a row and first-eligible-slot select.
// ============================================================================
`timescale 1ns / 1ps

module eet_slot_match
    import eet_pkg::*;
(
    input  tag_row_t            tags,
    input  logic [COL_BITS-1:0] col,
    output match_t              result
);

    logic [SLOTS_PER_ROW-1:0] elig;
    logic [SLOTS_PER_ROW-1:0] valid_vec;
    logic [SLOTS_PER_ROW-1:0] first;
    logic [SLOT_BITS-1:0]     slot_idx;

    // Slots fill from the bottom and are never freed, so the first slot
    // that is either empty or holds the column decides both reads and writes.
    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_ROW; i++)
        begin
            valid_vec[i] = tags[i].valid;
            elig[i]      = !tags[i].valid || (tags[i].col == col);
        end
    end

    assign first = elig & (~elig + SLOTS_PER_ROW'(1));

    always_comb
    begin
        slot_idx = '0;
        for (int b = 0; b < SLOT_BITS; b++)
        begin
            for (int i = 0; i < SLOTS_PER_ROW; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    slot_idx[b] = slot_idx[b] | first[i];
                end
            end
        end
    end

    assign result.found = |elig;
    assign result.hit   = |(first & valid_vec);
    assign result.slot  = slot_idx;

endmodule

>>> rtl/ellpack_element_table.sv
// ============================================================================
// ellpack_element_table
// Sparse matrix element store in ELLPACK form with per-element read/write.
// ============================================================================
// Usage:
// Each input word on the s_ side carries one access: s_tuser selects a read
// (0) or a write (1), s_tdata holds the row, the column and the value to
// store. Each accepted word yields exactly one result word on the m_ side
// with the read value, a present flag, the slot used, the fill density and,
// on m_tuser, the status (ok, index out of range, row full).
// An access runs in an accept step and a lookup step. On acceptance the
// whole row of tags and values is read from the two row-wide memories into
// their read registers; in the lookup step all slots are compared at once,
// one slot is written back and the result register is loaded. The block
// takes no new word until the lookup step of the current word has ended,
// and as a write completes before the next read, no forwarding is needed.
// After reset all 1024 rows of the tag memory are cleared, one row a cycle,
// while s_tready stays low; configuration writes are taken at any time.
// When the receiver stalls, the result register holds its word and one more
// access may be accepted; that access then waits in its lookup step, and
// the memories are not touched until the result register frees up.
// ============================================================================
`timescale 1ns / 1ps
`include "ellpack_element_table_assert.svh"

module ellpack_element_table
    import eet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration write port.
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data,

    // Access words.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [9:0] row_index, [19:10] column_index, [51:20] write_value, rest zero
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // [0] mode
    input  logic                     s_tuser,

    // Result words.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [31:0] read_value, [32] present, [37:33] slot_used,
    // [43:38] fill_density, rest zero
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // [1:0] status
    output logic [STATUS_BITS-1:0]   m_tuser
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_LOOKUP = 1'b1;

    // Control state.
    logic                 state_reg, state_next;
    logic                 clr_active_reg, clr_active_next;
    logic [ROW_BITS-1:0]  clr_row_reg, clr_row_next;
    logic [DENS_BITS-1:0] density_reg, density_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [CFG_BITS-1:0]  row_count_reg;
    logic [CFG_BITS-1:0]  column_count_reg;

    // Accepted access.
    logic                    mode_reg;
    logic [ROW_IDX_BITS-1:0] row_reg;
    logic [COL_IDX_BITS-1:0] col_reg;
    logic [WVAL_BITS-1:0]    wval_reg;

    // Result register.
    logic [RVAL_BITS-1:0]   out_value_reg;
    logic                   out_present_reg;
    logic [SLOT_BITS-1:0]   out_slot_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [DENS_BITS-1:0]   out_density_reg;

    logic                   accept;
    logic                   finish;
    logic                   range_bad;
    logic                   do_write;
    logic                   do_claim;
    logic [DENS_BITS-1:0]   claim_count;
    tag_row_t               tag_row;
    value_row_t             value_row;
    match_t                 match;
    slot_wr_t               slot_wr;
    tag_t                   wr_tag;
    logic [RVAL_BITS-1:0]   res_value;
    logic                   res_present;
    logic [SLOT_BITS-1:0]   res_slot;
    logic [STATUS_BITS-1:0] res_status;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE) && !clr_active_reg;
    assign accept   = s_tvalid && s_tready;
    // The lookup step completes only when the result register can take it.
    assign finish   = (state_reg == S_LOOKUP) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // Memories and slot scan
    // ------------------------------------------------------------------
    eet_tag_mem u_tag_mem (
        .clk      (clk),
        .rd_en    (accept),
        .rd_row   (ROW_BITS'(s_tdata[ROW_IDX_BITS-1:0])),
        .rd_data  (tag_row),
        .wr       (slot_wr),
        .wr_entry (wr_tag),
        .clr_en   (clr_active_reg),
        .clr_row  (clr_row_reg)
    );

    eet_value_mem u_value_mem (
        .clk      (clk),
        .rd_en    (accept),
        .rd_row   (ROW_BITS'(s_tdata[ROW_IDX_BITS-1:0])),
        .rd_data  (value_row),
        .wr       (slot_wr),
        .wr_value (VALUE_BITS'(wval_reg))
    );

    eet_slot_match u_slot_match (
        .tags   (tag_row),
        .col    (COL_BITS'(col_reg)),
        .result (match)
    );

    // ------------------------------------------------------------------
    // Lookup decision
    // ------------------------------------------------------------------
    always_comb
    begin
        range_bad = ({1'b0, row_reg} >= row_count_reg)
                 || (32'(row_reg) >= 32'(MAX_ROWS))
                 || ({1'b0, col_reg} >= column_count_reg)
                 || (32'(col_reg) >= 32'(MAX_COLUMNS));

        do_write    = 1'b0;
        res_value   = '0;
        res_present = 1'b0;
        res_slot    = '0;
        res_status  = STATUS_OK;

        if (range_bad)
        begin
            res_status = STATUS_RANGE;
        end
        else if (mode_reg == MODE_READ)
        begin
            if (match.hit)
            begin
                res_value   = RVAL_BITS'(value_row[match.slot]);
                res_present = 1'b1;
                res_slot    = match.slot;
            end
        end
        else if (match.found)
        begin
            do_write    = 1'b1;
            res_present = 1'b1;
            res_slot    = match.slot;
        end
        else
        begin
            res_status = STATUS_FULL;
        end
    end

    // A write into an empty slot claims it and may raise the density.
    assign do_claim    = do_write && !match.hit;
    assign claim_count = DENS_BITS'(match.slot) + DENS_BITS'(1);

    assign slot_wr.we   = finish && do_write;
    assign slot_wr.row  = ROW_BITS'(row_reg);
    assign slot_wr.slot = match.slot;
    assign wr_tag.valid = 1'b1;
    assign wr_tag.col   = COL_BITS'(col_reg);

    always_comb
    begin
        density_next = density_reg;
        if (finish && do_claim && (claim_count > density_reg))
        begin
            density_next = claim_count;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Tag clearing sweep after reset.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg)
        begin
            if (clr_row_reg == ROW_BITS'(MAX_ROWS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_row_next = clr_row_reg + ROW_BITS'(1);
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            clr_active_reg   <= 1'b1;
            clr_row_reg      <= '0;
            density_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            density_reg    <= density_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            row_reg  <= s_tdata[ROW_IDX_BITS-1:0];
            col_reg  <= s_tdata[ROW_IDX_BITS +: COL_IDX_BITS];
            wval_reg <= s_tdata[ROW_IDX_BITS + COL_IDX_BITS +: WVAL_BITS];
        end
        if (finish)
        begin
            out_value_reg   <= res_value;
            out_present_reg <= res_present;
            out_slot_reg    <= res_slot;
            out_status_reg  <= res_status;
            out_density_reg <= density_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0), out_density_reg,
                       out_slot_reg, out_present_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EET_ASSERT_SAME(a_no_accept_in_clear, clr_active_reg, !s_tready,
                     "access accepted during tag clear")
    `EET_ASSERT_SAME(a_write_in_lookup, slot_wr.we,
                     (state_reg == S_LOOKUP) && !clr_active_reg && !range_bad,
                     "slot written outside a valid lookup step")
    `EET_ASSERT_NEXT(a_density_monotone, 1'b1, density_reg >= $past(density_reg),
                     "fill density decreased")
    `EET_ASSERT_NEXT(a_stall_holds_lookup,
                     (state_reg == S_LOOKUP) && m_tvalid_reg && !m_tready,
                     state_reg == S_LOOKUP,
                     "lookup completed while result register was full")

endmodule
